// File: sv/invc_pkg.sv
//------------------------------------------------------------------------------
// invc_pkg: shared types and constants for the inversion counter
// Holds store sizing, count width and the command bundle from the
// sequencer to the merge unit.
//------------------------------------------------------------------------------
package invc_pkg;

	localparam int unsigned MAX_ELEMENTS = 1024;
	localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int unsigned FILL_W = ADDR_W + 1;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned COUNT_W = 31;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Command from the sequencer to the merge unit for one pass.
	typedef struct packed {
		logic  start;
		fill_t width;
		fill_t n;
	} pass_cmd_t;

endpackage

// File: sv/invc_merge.sv
//------------------------------------------------------------------------------
// invc_merge: one merge pass over the store
// Merges all run pairs of a given width from the element store into the
// scratch store, then copies the scratch back, adding to the inversion count.
//------------------------------------------------------------------------------
module invc_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  invc_pkg::pass_cmd_t cmd,
	input  logic                clear_count,
	input  logic                load_we,
	input  invc_pkg::addr_t     load_addr,
	input  invc_pkg::data_t     load_data,
	output logic                done,
	output invc_pkg::count_t    count
);

	typedef enum logic [5:0] {
		M_IDLE  = 6'b000001,
		M_SEG   = 6'b000010,
		M_RD    = 6'b000100,
		M_CMP   = 6'b001000,
		M_CPRD  = 6'b010000,
		M_CPWR  = 6'b100000
	} mstate_t;

	mstate_t state_q;
	invc_pkg::data_t store_mem [invc_pkg::MAX_ELEMENTS];
	invc_pkg::data_t scratch_mem [invc_pkg::MAX_ELEMENTS];
	invc_pkg::data_t rd_a_q, rd_b_q, scr_rd_q;
	invc_pkg::fill_t width_q, n_q, lo_q, i_q, j_q, k_q, mid_q, hi_q;
	invc_pkg::count_t count_q;
	logic [invc_pkg::FILL_W:0] hi_full;
	logic a_ok, b_ok, take_b, st_we, sc_we;
	invc_pkg::addr_t st_waddr, sc_waddr;
	invc_pkg::data_t st_wdata, sc_wdata;

	assign a_ok = i_q < mid_q;
	assign b_ok = j_q < hi_q;
	// Signed compare: store value at i strictly greater than value at j.
	assign take_b = b_ok && (!a_ok || ($signed(rd_a_q) > $signed(rd_b_q)));
	assign hi_full = {1'b0, lo_q} + {width_q, 1'b0};

	// The pass ends in the cycle that finds the copy-back finished, so the
	// sequencer has dropped its start by the time this unit is idle again.
	assign done = (state_q == M_CPRD) && !(k_q < hi_q);

	// Store write port: loading while idle, copy-back during a pass.
	always_comb begin
		st_we = load_we;
		st_waddr = load_addr;
		st_wdata = load_data;
		if (state_q == M_CPWR) begin
			st_we = 1'b1;
			st_waddr = k_q[invc_pkg::ADDR_W-1:0];
			st_wdata = scr_rd_q;
		end
		sc_we = (state_q == M_CMP) && (a_ok || b_ok);
		sc_waddr = k_q[invc_pkg::ADDR_W-1:0];
		sc_wdata = take_b ? rd_b_q : rd_a_q;
	end

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		rd_a_q <= store_mem[i_q[invc_pkg::ADDR_W-1:0]];
		rd_b_q <= store_mem[j_q[invc_pkg::ADDR_W-1:0]];
		if (sc_we) begin
			scratch_mem[sc_waddr] <= sc_wdata;
		end
		scr_rd_q <= scratch_mem[k_q[invc_pkg::ADDR_W-1:0]];
	end

	// Pass sequencer: segment setup, element merge, copy back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			count_q <= '0;
			width_q <= '0; n_q <= '0; lo_q <= '0; i_q <= '0; j_q <= '0;
			k_q <= '0; mid_q <= '0; hi_q <= '0;
		end else begin
			if (clear_count) begin
				count_q <= '0;
			end
			case (state_q)
				M_IDLE: begin
					if (cmd.start) begin
						width_q <= cmd.width;
						n_q <= cmd.n;
						lo_q <= '0;
						state_q <= M_SEG;
					end
				end
				M_SEG: begin
					// Set up a run pair, or go copy back when none is left.
					if ({1'b0, lo_q} + {1'b0, width_q} < {1'b0, n_q}) begin
						i_q <= lo_q;
						j_q <= lo_q + width_q;
						mid_q <= lo_q + width_q;
						k_q <= lo_q;
						hi_q <= (hi_full < {1'b0, n_q}) ?
							hi_full[invc_pkg::FILL_W-1:0] : n_q;
						state_q <= M_RD;
					end else begin
						k_q <= '0;
						hi_q <= lo_q;
						state_q <= M_CPRD;
					end
				end
				M_RD: begin
					state_q <= M_CMP;
				end
				M_CMP: begin
					if (a_ok || b_ok) begin
						k_q <= k_q + 1'b1;
						if (take_b) begin
							j_q <= j_q + 1'b1;
							if (a_ok) begin
								count_q <= count_q +
									invc_pkg::COUNT_W'(mid_q - i_q);
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
						state_q <= M_RD;
					end else begin
						lo_q <= hi_q;
						state_q <= M_SEG;
					end
				end
				M_CPRD: begin
					if (k_q < hi_q) begin
						state_q <= M_CPWR;
					end else begin
						state_q <= M_IDLE;
					end
				end
				M_CPWR: begin
					k_q <= k_q + 1'b1;
					state_q <= M_CPRD;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign count = count_q;

endmodule

// File: sv/inversion_counter.sv
//------------------------------------------------------------------------------
// inversion_counter: inversion count by bottom-up merge sort
// Loads signed elements, sorts them on the last request and reports the count.
//------------------------------------------------------------------------------
// Element requests are taken while loading. A last request starts
// ceil(log2 N) merge passes over the stored N elements through a single
// shared compare unit on two store read ports. Each merged element passes
// a read and a compare state, each copied-back element a read and a write
// state. Up to 1024 elements are kept; later ones are dropped. An empty-set
// request answers 0 in the next cycle.
//------------------------------------------------------------------------------
module inversion_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] element_value,
	input  logic        last_element,
	input  logic        empty_set,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] inversion_count
);

	typedef enum logic [3:0] {
		S_LOAD = 4'b0001,
		S_PASS = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	invc_pkg::fill_t fill_q, width_q;
	invc_pkg::pass_cmd_t cmd;
	invc_pkg::count_t merge_count, result_q;
	logic pass_done, accept, load_we, clear_count;

	assign in_ready = (state_q == S_LOAD);
	assign accept = in_valid && in_ready;
	assign load_we = accept && !empty_set && (fill_q < invc_pkg::fill_t'(invc_pkg::MAX_ELEMENTS));
	assign clear_count = accept;
	assign cmd.start = (state_q == S_PASS);
	assign cmd.width = width_q;
	assign cmd.n = fill_q;

	invc_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.clear_count(clear_count),
		.load_we(load_we),
		.load_addr(fill_q[invc_pkg::ADDR_W-1:0]),
		.load_data(element_value),
		.done(pass_done),
		.count(merge_count)
	);

	// Top sequencer: load, run passes of doubling width, present result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			fill_q <= '0;
			width_q <= '0;
			result_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (empty_set) begin
							fill_q <= '0;
							result_q <= '0;
							state_q <= S_OUT;
						end else begin
							if (load_we) begin
								fill_q <= fill_q + 1'b1;
							end
							if (last_element) begin
								width_q <= invc_pkg::fill_t'(1);
								state_q <= S_WAIT;
							end
						end
					end
				end
				S_WAIT: begin
					// Decide whether another pass is needed.
					if (width_q < fill_q) begin
						state_q <= S_PASS;
					end else begin
						result_q <= merge_count;
						fill_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_PASS: begin
					if (pass_done) begin
						width_q <= {width_q[invc_pkg::FILL_W-2:0], 1'b0};
						state_q <= S_WAIT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign inversion_count = result_q;

	// No request is taken while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken during result");
	// An empty-set request answers zero next cycle.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty_set) |=> (out_valid && inversion_count == '0))
		else $error("empty set not answered with zero");
	// Fill never exceeds capacity.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= invc_pkg::fill_t'(invc_pkg::MAX_ELEMENTS))
		else $error("fill count overflow");

endmodule
